// ===== hw/rtl/scatr_pkg.sv =====
// ----------------------------------------------------------------------------
// scatr_pkg
// Shared types and codes for the answer-to-reset parser: request and
// response payloads, status and error codes, protocol constants.
// ----------------------------------------------------------------------------
package scatr_pkg;

   localparam logic [7:0] TS_DIRECT    = 8'h3B;
   localparam logic [7:0] IFSC_DEFAULT = 8'h20;
   localparam logic [3:0] PROTO_T1     = 4'h1;
   localparam logic [1:0] GROUP_FIRST  = 2'd1;
   localparam logic [1:0] GROUP_LATE   = 2'd3;

   localparam logic [1:0] ST_MORE     = 2'd0;
   localparam logic [1:0] ST_COMPLETE = 2'd1;
   localparam logic [1:0] ST_ERROR    = 2'd2;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_CONVENTION = 3'd1;
   localparam logic [2:0] ERR_TRUNCATED  = 3'd2;
   localparam logic [2:0] ERR_TOO_LONG   = 3'd3;
   localparam logic [2:0] ERR_CHECKSUM   = 3'd4;

   typedef struct packed {
      logic [7:0] atr_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] error_kind;
      logic [3:0] protocol;
      logic [7:0] ifsc;
      logic       crc_mode;
   } rsp_type;

endpackage

// ===== hw/rtl/scatr_parse.sv =====
// ----------------------------------------------------------------------------
// scatr_parse
// Parse state and single-pass update logic: takes one ATR byte per accepted
// request and forms the response for it.
// ----------------------------------------------------------------------------
module scatr_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  scatr_pkg::req_type req,
   output scatr_pkg::rsp_type rsp
);

   typedef enum logic [2:0] {
      PH_TS    = 3'd0,
      PH_T0    = 3'd1,
      PH_IFACE = 3'd2,
      PH_HIST  = 3'd3,
      PH_TCK   = 3'd4,
      PH_DONE  = 3'd5,
      PH_ERR   = 3'd6
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] pending_ff, pending_in;
   logic [1:0] group_ff, group_in;
   logic [3:0] proto_ff, proto_in;
   logic [3:0] hist_ff, hist_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] ifsc_ff, ifsc_in;
   logic       crc_ff, crc_in;

   logic [7:0] b;
   logic       late;
   logic [2:0] fail;
   logic [1:0] status;
   logic [2:0] kind;

   assign b    = req.atr_byte;
   assign late = (group_ff == scatr_pkg::GROUP_LATE) && (proto_ff == scatr_pkg::PROTO_T1);

   always_comb begin
      phase_in   = phase_ff;
      pending_in = pending_ff;
      group_in   = group_ff;
      proto_in   = proto_ff;
      hist_in    = hist_ff;
      xor_in     = xor_ff;
      ifsc_in    = ifsc_ff;
      crc_in     = crc_ff;
      fail       = scatr_pkg::ERR_NONE;
      status     = scatr_pkg::ST_MORE;
      kind       = scatr_pkg::ERR_NONE;
      case (phase_ff)
         PH_TS: begin
            if (b != scatr_pkg::TS_DIRECT) begin
               fail = scatr_pkg::ERR_CONVENTION;
            end else begin
               phase_in = PH_T0;
            end
         end
         PH_T0: begin
            xor_in     = b;
            pending_in = b[7:4];
            hist_in    = b[3:0];
            group_in   = scatr_pkg::GROUP_FIRST;
            if (b[7:4] != 4'd0) begin
               phase_in = PH_IFACE;
            end else if (b[3:0] != 4'd0) begin
               phase_in = PH_HIST;
            end else begin
               phase_in = PH_TCK;
            end
         end
         PH_IFACE: begin
            xor_in = xor_ff ^ b;
            if (pending_ff[0]) begin
               pending_in = {pending_ff[3:1], 1'b0};
               if (late) begin
                  ifsc_in = b;
               end
            end else if (pending_ff[1]) begin
               pending_in = {pending_ff[3:2], 2'b00};
            end else if (pending_ff[2]) begin
               pending_in = {pending_ff[3], 3'b000};
               if (late) begin
                  crc_in = b[0];
               end
            end else begin
               pending_in = b[7:4];
               proto_in   = b[3:0];
               if (group_ff != scatr_pkg::GROUP_LATE) begin
                  group_in = group_ff + 2'd1;
               end
            end
            if (pending_in == 4'd0) begin
               if (hist_ff != 4'd0) begin
                  phase_in = PH_HIST;
               end else begin
                  phase_in = PH_TCK;
               end
            end
         end
         PH_HIST: begin
            xor_in  = xor_ff ^ b;
            hist_in = hist_ff - 4'd1;
            if (hist_in == 4'd0) begin
               phase_in = PH_TCK;
            end
         end
         PH_TCK: begin
            xor_in = xor_ff ^ b;
            if (xor_in != 8'd0) begin
               fail = scatr_pkg::ERR_CHECKSUM;
            end else begin
               phase_in = PH_DONE;
               status   = scatr_pkg::ST_COMPLETE;
            end
         end
         PH_ERR: begin
            status = scatr_pkg::ST_ERROR;
            kind   = pending_ff[2:0];
         end
         default: begin
            fail = scatr_pkg::ERR_TOO_LONG;
         end
      endcase
      if (fail != scatr_pkg::ERR_NONE) begin
         phase_in   = PH_ERR;
         pending_in = {1'b0, fail};
         status     = scatr_pkg::ST_ERROR;
         kind       = fail;
      end
      if (req.last_byte && (status == scatr_pkg::ST_MORE)) begin
         status = scatr_pkg::ST_ERROR;
         kind   = scatr_pkg::ERR_TRUNCATED;
      end
   end

   assign rsp.status     = status;
   assign rsp.error_kind = kind;
   assign rsp.protocol   = proto_in;
   assign rsp.ifsc       = ifsc_in;
   assign rsp.crc_mode   = crc_in;

   always_ff @(posedge clock) begin
      if (reset || (accept && req.last_byte)) begin
         phase_ff   <= PH_TS;
         pending_ff <= 4'd0;
         group_ff   <= scatr_pkg::GROUP_FIRST;
         proto_ff   <= 4'd0;
         hist_ff    <= 4'd0;
         xor_ff     <= 8'd0;
         ifsc_ff    <= scatr_pkg::IFSC_DEFAULT;
         crc_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         group_ff   <= group_in;
         proto_ff   <= proto_in;
         hist_ff    <= hist_in;
         xor_ff     <= xor_in;
         ifsc_ff    <= ifsc_in;
         crc_ff     <= crc_in;
      end
   end

endmodule

// ===== hw/rtl/scatr_out_reg.sv =====
// ----------------------------------------------------------------------------
// scatr_out_reg
// Response register: holds one response until the consumer takes it and
// reports when a new one may be loaded.
// ----------------------------------------------------------------------------
module scatr_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  scatr_pkg::rsp_type load_data,
   output logic               can_load,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output scatr_pkg::rsp_type rsp_data
);

   logic               valid_ff;
   scatr_pkg::rsp_type data_ff;

   assign can_load  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

// ===== hw/rtl/smartcard_atr_parser.sv =====
// ----------------------------------------------------------------------------
// smartcard_atr_parser
// Direct-convention ISO 7816-3 answer-to-reset parser with one response per
// request byte.
// ----------------------------------------------------------------------------
// Each request carries one ATR byte, TS first, and a last-byte mark. The
// response for a request appears on the rsp channel in the cycle after the
// request is accepted and reports status, error cause, protocol, IFSC and
// CRC/LRC choice as they stand after that byte. One request is accepted per
// cycle as long as the response register is empty or being drained. A
// request with the last-byte mark returns the parser to its reset state.
module smartcard_atr_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  scatr_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output scatr_pkg::rsp_type rsp_data
);

   logic               accept;
   scatr_pkg::rsp_type result;

   assign accept = req_valid && req_ready;

   scatr_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .rsp    (result)
   );

   scatr_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (result),
      .can_load  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/scatr_checker.sv =====
// ----------------------------------------------------------------------------
// scatr_checker
// Port-level checks for the answer-to-reset parser, bound to the top level.
// ----------------------------------------------------------------------------
module scatr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input scatr_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after accepted request");

   a_kind_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != scatr_pkg::ST_ERROR) |->
         rsp_data.error_kind == scatr_pkg::ERR_NONE)
      else $error("error cause without error status");

   a_kind_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == scatr_pkg::ST_ERROR) |->
         (rsp_data.error_kind == scatr_pkg::ERR_CONVENTION) ||
         (rsp_data.error_kind == scatr_pkg::ERR_TRUNCATED) ||
         (rsp_data.error_kind == scatr_pkg::ERR_TOO_LONG) ||
         (rsp_data.error_kind == scatr_pkg::ERR_CHECKSUM))
      else $error("error status without a known cause");

endmodule

bind smartcard_atr_parser scatr_checker u_scatr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
